FILE: hw/rtl/ashtr_pkg.sv
// ----------------------------------------------------------------------------
// ashtr_pkg
// Types, constants and helpers shared by the ADC scan hysteresis trigger.
// ----------------------------------------------------------------------------
package ashtr_pkg;

  // Scan geometry and arming delay.
  localparam int SCAN_SLOTS = 4;
  localparam int ARM_ROUNDS = 20;
  localparam int CHAN_CNT   = 4;

  // Field widths.
  localparam int SAMPLE_W  = 10;
  localparam int SLOT_W    = 2;
  localparam int ROUNDS_W  = 5;
  localparam int THR_W     = 16;
  localparam int HYST_W    = 8;
  localparam int MUX_W     = 8;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  // Mux setting of channel 0 after reset; channel i gets this plus i.
  localparam logic [MUX_W-1:0] MUX_RESET_BASE = 8'h40;

  // Per-channel trigger state.
  typedef enum logic [1:0] {
    TS_ARMED = 2'd0,
    TS_POS   = 2'd1,
    TS_NEG   = 2'd2,
    TS_INIT  = 2'd3
  } trig_state_t;

  // Event codes reported with each evaluated sample.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ARMED    = 3'd1,
    EV_POS_TRIG = 3'd2,
    EV_NEG_TRIG = 3'd3,
    EV_EXIT_POS = 3'd4,
    EV_EXIT_NEG = 3'd5
  } event_t;

  // Settle sequence after each mux change.
  typedef enum logic [1:0] {
    PH_READ    = 2'd0,
    PH_SETTLE1 = 2'd1,
    PH_SETTLE2 = 2'd2
  } settle_phase_t;

  // One channel configuration word, positive threshold in the low bits.
  typedef struct packed {
    logic [MUX_W-1:0]  mux;
    logic [HYST_W-1:0] hyst;
    logic [THR_W-1:0]  neg;
    logic [THR_W-1:0]  pos;
  } chan_cfg_t;

  // One result item.
  typedef struct packed {
    logic [SLOT_W-1:0] channel;
    event_t            event_res;
    logic [MUX_W-1:0]  next_mux;
  } result_t;

  // Reset value of a channel configuration word.
  function automatic chan_cfg_t cfg_reset(input logic [SLOT_W-1:0] idx);
    chan_cfg_t c;
    c      = '0;
    c.mux  = MUX_RESET_BASE + MUX_W'(idx);
    return c;
  endfunction

endpackage

FILE: hw/rtl/ashtr_if.sv
// ----------------------------------------------------------------------------
// ashtr_if
// Valid/ready channels for conversion samples and trigger results.
// ----------------------------------------------------------------------------
interface ashtr_sample_if;
  logic                          valid;
  logic                          ready;
  logic [ashtr_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ashtr_result_if;
  logic                          valid;
  logic                          ready;
  logic [ashtr_pkg::SLOT_W-1:0]  channel;
  logic [2:0]                    event_res;
  logic [ashtr_pkg::MUX_W-1:0]   next_mux;

  modport source (output valid, output channel, output event_res, output next_mux,
                  input ready);
  modport sink   (input valid, input channel, input event_res, input next_mux,
                  output ready);
endinterface

FILE: hw/rtl/ashtr_cfg_regs.sv
// ----------------------------------------------------------------------------
// ashtr_cfg_regs
// Per-channel threshold, hysteresis and mux configuration registers.
// ----------------------------------------------------------------------------
module ashtr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ashtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ashtr_pkg::CFG_W-1:0]     cfg_data,
  output ashtr_pkg::chan_cfg_t            chan_cfg [ashtr_pkg::CHAN_CNT]
);

  logic idx_valid;

  // Writes beyond the last channel are dropped.
  assign idx_valid = cfg_index < ashtr_pkg::CFG_IDX_W'(ashtr_pkg::CHAN_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ashtr_pkg::CHAN_CNT; i++) begin
        chan_cfg[i] <= ashtr_pkg::cfg_reset(ashtr_pkg::SLOT_W'(i));
      end
    end else if (cfg_we && idx_valid) begin
      chan_cfg[cfg_index[ashtr_pkg::SLOT_W-1:0]] <= ashtr_pkg::chan_cfg_t'(cfg_data);
    end
  end

endmodule

FILE: hw/rtl/ashtr_eval.sv
// ----------------------------------------------------------------------------
// ashtr_eval
// Input register, scan state and the per-sample trigger evaluation.
// ----------------------------------------------------------------------------
module ashtr_eval (
  input  logic                 clk,
  input  logic                 rst,
  ashtr_sample_if.sink         sample_in,
  input  ashtr_pkg::chan_cfg_t chan_cfg [ashtr_pkg::CHAN_CNT],
  output ashtr_pkg::result_t   res,
  output logic                 res_valid,
  input  logic                 res_free
);

  localparam int SLOT_CNT_W = ashtr_pkg::SLOT_W + 1;

  // Input register.
  logic                            s1_valid;
  logic [ashtr_pkg::SAMPLE_W-1:0]  s1_sample;
  logic                            s1_advance;

  // Scan and trigger state.
  ashtr_pkg::settle_phase_t        phase;
  ashtr_pkg::settle_phase_t        phase_next;
  logic [ashtr_pkg::SLOT_W-1:0]    slot;
  logic [ashtr_pkg::SLOT_W-1:0]    slot_next;
  logic [ashtr_pkg::ROUNDS_W-1:0]  rounds;
  logic [ashtr_pkg::ROUNDS_W-1:0]  rounds_next;
  logic [ashtr_pkg::SAMPLE_W-1:0]  prev_sample [ashtr_pkg::CHAN_CNT];
  ashtr_pkg::trig_state_t          trig_state  [ashtr_pkg::CHAN_CNT];
  ashtr_pkg::trig_state_t          ts_next;
  ashtr_pkg::event_t               ev;

  // Evaluation operands.
  ashtr_pkg::chan_cfg_t            cur_cfg;
  logic [ashtr_pkg::THR_W-1:0]     old_w;
  logic [ashtr_pkg::THR_W-1:0]     now_w;
  logic [ashtr_pkg::THR_W-1:0]     pos_ret;
  logic [ashtr_pkg::THR_W-1:0]     neg_ret;
  logic [SLOT_CNT_W-1:0]           slot_inc;
  logic                            is_read;

  assign is_read = (phase == ashtr_pkg::PH_READ);

  // Settle items leave at once; read items wait for room in the output register.
  assign s1_advance      = s1_valid && (!is_read || res_free);
  assign sample_in.ready = !s1_valid || s1_advance;
  assign res_valid       = s1_valid && is_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_in.valid && sample_in.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      s1_sample <= sample_in.sample;
    end
  end

  // Settle phase sequence: read, then two discarded conversions.
  always_comb begin
    case (phase)
      ashtr_pkg::PH_READ:    phase_next = ashtr_pkg::PH_SETTLE1;
      ashtr_pkg::PH_SETTLE1: phase_next = ashtr_pkg::PH_SETTLE2;
      default:               phase_next = ashtr_pkg::PH_READ;
    endcase
  end

  // Operands of the current slot; thresholds for the return wrap at 16 bits.
  assign cur_cfg = chan_cfg[slot];
  assign old_w   = ashtr_pkg::THR_W'(prev_sample[slot]);
  assign now_w   = ashtr_pkg::THR_W'(s1_sample);
  assign pos_ret = cur_cfg.pos - ashtr_pkg::THR_W'(cur_cfg.hyst);
  assign neg_ret = cur_cfg.neg + ashtr_pkg::THR_W'(cur_cfg.hyst);

  // Trigger state transition and event code.
  always_comb begin
    ts_next = trig_state[slot];
    ev      = ashtr_pkg::EV_NONE;
    case (trig_state[slot])
      ashtr_pkg::TS_ARMED: begin
        if (old_w < cur_cfg.pos && now_w >= cur_cfg.pos) begin
          ts_next = ashtr_pkg::TS_POS;
          ev      = ashtr_pkg::EV_POS_TRIG;
        end
        if (old_w > cur_cfg.neg && now_w <= cur_cfg.neg) begin
          ts_next = ashtr_pkg::TS_NEG;
          ev      = ashtr_pkg::EV_NEG_TRIG;
        end
      end
      ashtr_pkg::TS_POS: begin
        if (old_w > pos_ret && now_w <= pos_ret) begin
          ts_next = ashtr_pkg::TS_ARMED;
          ev      = ashtr_pkg::EV_EXIT_POS;
        end
      end
      ashtr_pkg::TS_NEG: begin
        if (old_w < neg_ret && now_w >= neg_ret) begin
          ts_next = ashtr_pkg::TS_ARMED;
          ev      = ashtr_pkg::EV_EXIT_NEG;
        end
      end
      default: begin
        if (rounds >= ashtr_pkg::ROUNDS_W'(ashtr_pkg::ARM_ROUNDS)) begin
          ts_next = ashtr_pkg::TS_ARMED;
          ev      = ashtr_pkg::EV_ARMED;
        end
      end
    endcase
  end

  // Slot advance with wrap; full scans counted up to the arming limit.
  always_comb begin
    slot_inc    = SLOT_CNT_W'(slot) + SLOT_CNT_W'(1);
    slot_next   = slot_inc[ashtr_pkg::SLOT_W-1:0];
    rounds_next = rounds;
    if (slot_inc >= SLOT_CNT_W'(ashtr_pkg::SCAN_SLOTS)) begin
      slot_next = '0;
      if (rounds < ashtr_pkg::ROUNDS_W'(ashtr_pkg::ARM_ROUNDS)) begin
        rounds_next = rounds + ashtr_pkg::ROUNDS_W'(1);
      end
    end
  end

  // Result of a read step.
  assign res.channel   = slot;
  assign res.event_res = ev;
  assign res.next_mux  = chan_cfg[slot_next].mux;

  // State update as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= ashtr_pkg::PH_READ;
      slot   <= '0;
      rounds <= '0;
      for (int i = 0; i < ashtr_pkg::CHAN_CNT; i++) begin
        prev_sample[i] <= '0;
        trig_state[i]  <= ashtr_pkg::TS_INIT;
      end
    end else if (s1_advance) begin
      phase <= phase_next;
      if (is_read) begin
        prev_sample[slot] <= s1_sample;
        trig_state[slot]  <= ts_next;
        slot              <= slot_next;
        rounds            <= rounds_next;
      end
    end
  end

endmodule

FILE: hw/rtl/ashtr_out_reg.sv
// ----------------------------------------------------------------------------
// ashtr_out_reg
// Result register that drives the output channel.
// ----------------------------------------------------------------------------
module ashtr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  ashtr_pkg::result_t res,
  input  logic               res_valid,
  output logic               res_free,
  ashtr_result_if.source     result_out
);

  logic               out_valid;
  ashtr_pkg::result_t out_data;

  // Room when empty or when the held result transfers this cycle.
  assign res_free = !out_valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_data <= res;
    end
  end

  assign result_out.valid     = out_valid;
  assign result_out.channel   = out_data.channel;
  assign result_out.event_res = out_data.event_res;
  assign result_out.next_mux  = out_data.next_mux;

endmodule

FILE: hw/rtl/adc_scan_hysteresis_trigger_top.sv
// ----------------------------------------------------------------------------
// adc_scan_hysteresis_trigger_top
// Round-robin ADC scan with a per-channel window trigger and hysteresis.
//
//   Channel      Dir  Payload                              Transfer
//   sample_in    in   sample[9:0]                          valid & ready
//   result_out   out  channel[1:0] event_res[2:0] next_mux valid & ready
//   cfg          in   cfg_index[2:0] cfg_data[47:0]        cfg_we
//
// A sample is registered on transfer in the input register, where it is
// evaluated; its result is then registered in the output register. One sample is
// taken every cycle while the output register has room. Settle samples are
// dropped without a result and never wait on the output. Reset (rst,
// synchronous) sets all channels to init and the scan to slot 0, read phase.
// ----------------------------------------------------------------------------
module adc_scan_hysteresis_trigger_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ashtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ashtr_pkg::CFG_W-1:0]     cfg_data,
  ashtr_sample_if.sink                    sample_in,
  ashtr_result_if.source                  result_out
);

  ashtr_pkg::chan_cfg_t chan_cfg [ashtr_pkg::CHAN_CNT];
  ashtr_pkg::result_t   res;
  logic                 res_valid;
  logic                 res_free;

  // Configuration registers.
  ashtr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chan_cfg  (chan_cfg)
  );

  // Input register, scan state and evaluation.
  ashtr_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in),
    .chan_cfg  (chan_cfg),
    .res       (res),
    .res_valid (res_valid),
    .res_free  (res_free)
  );

  // Output register.
  ashtr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .res_valid  (res_valid),
    .res_free   (res_free),
    .result_out (result_out)
  );

endmodule
